>>> design/bpc_pkg.sv
package bpc_pkg;
  typedef enum logic [3:0] {
    ST_IDLE, ST_MLOAD, ST_MRUN, ST_DLOAD, ST_DRUN, ST_STEP
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } op_req_t;
endpackage

>>> design/bpc_mul.sv
module bpc_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  bpc_pkg::op_req_t req,
  output logic           busy,
  output logic [31:0]    prod
);
  import bpc_pkg::*;
  logic [31:0] a_r, a_nxt, b_r, b_nxt, p_r, p_nxt;
  logic [5:0]  cnt_r, cnt_nxt;

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    p_nxt = p_r;
    cnt_nxt = cnt_r;
    if (req.start) begin
      a_nxt = req.a;
      b_nxt = req.b;
      p_nxt = '0;
      cnt_nxt = 6'd32;
    end else if (cnt_r != 6'd0) begin
      if (b_r[0]) p_nxt = p_r + a_r;
      a_nxt = {a_r[30:0], 1'b0};
      b_nxt = {1'b0, b_r[31:1]};
      cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign busy = (cnt_r != 6'd0) || req.start;
  assign prod = p_r;
endmodule

>>> design/bpc_div.sv
module bpc_div (
  input  logic           clk,
  input  logic           rst_n,
  input  bpc_pkg::op_req_t req,
  output logic           busy,
  output logic [31:0]    quo
);
  import bpc_pkg::*;
  logic [31:0] n_r, n_nxt, d_r, d_nxt, q_r, q_nxt, rm_r, rm_nxt;
  logic [32:0] trial;
  logic [5:0]  cnt_r, cnt_nxt;

  always_comb begin
    n_nxt = n_r;
    d_nxt = d_r;
    q_nxt = q_r;
    rm_nxt = rm_r;
    cnt_nxt = cnt_r;
    trial = {rm_r, n_r[31]} - {1'b0, d_r};
    if (req.start) begin
      n_nxt = req.a;
      d_nxt = req.b;
      q_nxt = '0;
      rm_nxt = '0;
      cnt_nxt = 6'd32;
    end else if (cnt_r != 6'd0) begin
      if (!trial[32]) begin
        rm_nxt = trial[31:0];
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rm_nxt = {rm_r[30:0], n_r[31]};
        q_nxt = {q_r[30:0], 1'b0};
      end
      n_nxt = {n_r[30:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    n_r <= n_nxt;
    d_r <= d_nxt;
    q_r <= q_nxt;
    rm_r <= rm_nxt;
  end

  assign busy = (cnt_r != 6'd0) || req.start;
  assign quo = q_r;
endmodule

>>> design/barometric_pressure_compensation_core.sv
// channel | dir | signals
// in      | in  | in_valid in_ready in_func in_raw_sample
// out     | out | out_valid out_ready out_pressure_pa out_is_pressure out_divide_error
// cfg     | in  | cfg_valid cfg_ready cfg_index cfg_data
// Temperature beat: the result appears the cycle after accept.
// Pressure beat: 11 shift-add multiplies and 2 restoring divides on one shared multiplier
// and divider, each through load, run and step states. A zero X1 + md ends the beat
// after the first multiply, a zero B4 before the second divide. One beat is in flight at a time.
// Synchronous active-low reset clears calibration, UT, state.
// A stalled result holds in the output register; in_ready is low until taken.
module barometric_pressure_compensation_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [23:0] in_raw_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_pressure_pa,
  output logic        out_is_pressure,
  output logic        out_divide_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import bpc_pkg::*;

  localparam logic [1:0] REG_A = 2'd0, REG_B = 2'd1, REG_C = 2'd2, REG_OSS = 2'd3;

  state_t st_r, st_nxt;
  logic [63:0] ca_r, cb_r;
  logic [31:0] cc_r;
  logic [1:0]  oss_r;
  logic [15:0] ut_r, ut_nxt;
  logic [23:0] raw_r, raw_nxt;
  logic [4:0]  pc_r, pc_nxt;
  logic [31:0] x1_r, x1_nxt, b6_r, b6_nxt, sq_r, sq_nxt, b3_r, b3_nxt;
  logic [31:0] b4_r, b4_nxt, b7_r, b7_nxt, p_r, p_nxt;
  logic        sn_r, sn_nxt;
  logic [31:0] opa_r, opa_nxt, opb_r, opb_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] op_r, op_nxt;
  logic        oi_r, oi_nxt, oe_r, oe_nxt;
  op_req_t     mreq, dreq;
  logic        mbusy, dbusy;
  logic [31:0] prod, quo;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{ca_r[15]}}, ca_r[15:0]};
  assign ac2 = {{16{ca_r[31]}}, ca_r[31:16]};
  assign ac3 = {{16{ca_r[47]}}, ca_r[47:32]};
  assign ac4 = {16'd0, ca_r[63:48]};
  assign ac5 = {16'd0, cb_r[15:0]};
  assign ac6 = {16'd0, cb_r[31:16]};
  assign b1  = {{16{cb_r[47]}}, cb_r[47:32]};
  assign b2  = {{16{cb_r[63]}}, cb_r[63:48]};
  assign mc  = {{16{cc_r[15]}}, cc_r[15:0]};
  assign md  = {{16{cc_r[31]}}, cc_r[31:16]};

  bpc_mul u_mul (.clk, .rst_n, .req(mreq), .busy(mbusy), .prod);
  bpc_div u_div (.clk, .rst_n, .req(dreq), .busy(dbusy), .quo);

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r <= '0; cb_r <= '0; cc_r <= '0; oss_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_A:   ca_r <= cfg_data;
        REG_B:   cb_r <= cfg_data;
        REG_C:   cc_r <= cfg_data[31:0];
        REG_OSS: oss_r <= cfg_data[1:0];
      endcase
    end
  end

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
    return 32'($signed(v) >>> s);
  endfunction
  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? 32'd0 - v : v;
  endfunction

  assign in_ready = (st_r == ST_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_pressure_pa = op_r;
  assign out_is_pressure = oi_r;
  assign out_divide_error = oe_r;

  // micro-program: each pc value consumes the last mul or div result and, until the last, issues the next
  logic [31:0] tmp;
  always_comb begin
    st_nxt = st_r; pc_nxt = pc_r; ut_nxt = ut_r; raw_nxt = raw_r;
    x1_nxt = x1_r; b6_nxt = b6_r; sq_nxt = sq_r; b3_nxt = b3_r;
    b4_nxt = b4_r; b7_nxt = b7_r; p_nxt = p_r; sn_nxt = sn_r;
    opa_nxt = opa_r; opb_nxt = opb_r;
    ov_nxt = ov_r; op_nxt = op_r; oi_nxt = oi_r; oe_nxt = oe_r;
    mreq = '{start: 1'b0, a: opa_r, b: opb_r};
    dreq = '{start: 1'b0, a: opa_r, b: opb_r};
    tmp = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          raw_nxt = in_raw_sample;
          if (!in_func) begin
            ut_nxt = in_raw_sample[15:0];
            ov_nxt = 1'b1; op_nxt = '0; oi_nxt = 1'b0; oe_nxt = 1'b0;
          end else begin
            pc_nxt = 5'd0;
            opa_nxt = {16'd0, ut_r} - ac6; opb_nxt = ac5;
            st_nxt = ST_MLOAD;
          end
        end
      end
      ST_MLOAD: begin mreq.start = 1'b1; st_nxt = ST_MRUN; end
      ST_DLOAD: begin dreq.start = 1'b1; st_nxt = ST_DRUN; end
      ST_MRUN: if (!mbusy) st_nxt = ST_STEP;
      ST_DRUN: if (!dbusy) st_nxt = ST_STEP;
      ST_STEP: begin
        pc_nxt = pc_r + 5'd1;
        st_nxt = ST_MLOAD;
        unique case (pc_r)
          5'd0: begin
            x1_nxt = asr(prod, 5'd15);
            tmp = asr(prod, 5'd15) + md;
            if (tmp == 32'd0) begin
              ov_nxt = 1'b1; op_nxt = '0; oi_nxt = 1'b0; oe_nxt = 1'b1;
              st_nxt = ST_IDLE;
            end else begin
              sn_nxt = mc[31] ^ tmp[31];
              opa_nxt = mag({mc[20:0], 11'd0}); opb_nxt = mag(tmp);
              st_nxt = ST_DLOAD;
            end
          end
          5'd1: begin
            tmp = sn_r ? 32'd0 - quo : quo;
            b6_nxt = x1_r + tmp - 32'd4000;
            opa_nxt = x1_r + tmp - 32'd4000; opb_nxt = x1_r + tmp - 32'd4000;
          end
          5'd2: begin
            sq_nxt = asr(prod, 5'd12);
            opa_nxt = b2; opb_nxt = asr(prod, 5'd12);
          end
          5'd3: begin x1_nxt = asr(prod, 5'd11); opa_nxt = ac2; opb_nxt = b6_r; end
          5'd4: begin
            tmp = ((ac1 * 32'd4 + x1_r + asr(prod, 5'd11)) << oss_r) + 32'd2;
            b3_nxt = asr(tmp + (tmp[31] ? 32'd3 : 32'd0), 5'd2);
            opa_nxt = ac3; opb_nxt = b6_r;
          end
          5'd5: begin x1_nxt = asr(prod, 5'd13); opa_nxt = b1; opb_nxt = sq_r; end
          5'd6: begin
            tmp = asr(x1_r + asr(prod, 5'd16) + 32'd2, 5'd2) + 32'd32768;
            opa_nxt = ac4; opb_nxt = tmp;
          end
          5'd7: begin
            b4_nxt = prod >> 15;
            opa_nxt = {8'd0, raw_r} >> (4'd8 - {2'd0, oss_r}) ;
            opa_nxt = opa_nxt - b3_r;
            opb_nxt = 32'd50000 >> oss_r;
          end
          5'd8: begin
            b7_nxt = prod;
            if (b4_r == 32'd0) begin
              ov_nxt = 1'b1; op_nxt = '0; oi_nxt = 1'b0; oe_nxt = 1'b1;
              st_nxt = ST_IDLE;
            end else begin
              opa_nxt = prod[31] ? prod : {prod[30:0], 1'b0};
              opb_nxt = b4_r;
              st_nxt = ST_DLOAD;
            end
          end
          5'd9: begin
            tmp = b7_r[31] ? {quo[30:0], 1'b0} : quo;
            p_nxt = tmp;
            opa_nxt = asr(tmp, 5'd8); opb_nxt = asr(tmp, 5'd8);
          end
          5'd10: begin x1_nxt = prod; opa_nxt = prod; opb_nxt = 32'd3038; end
          5'd11: begin
            x1_nxt = asr(prod, 5'd16);
            opa_nxt = 32'd0 - 32'd7357; opb_nxt = p_r;
          end
          default: begin
            tmp = x1_r + asr(prod, 5'd16) + 32'd3791;
            ov_nxt = 1'b1; op_nxt = p_r + asr(tmp, 5'd4); oi_nxt = 1'b1; oe_nxt = 1'b0;
            st_nxt = ST_IDLE;
          end
        endcase
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ov_r <= 1'b0; ut_r <= '0; pc_r <= '0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; ut_r <= ut_nxt; pc_r <= pc_nxt;
    end
    raw_r <= raw_nxt; x1_r <= x1_nxt; b6_r <= b6_nxt; sq_r <= sq_nxt;
    b3_r <= b3_nxt; b4_r <= b4_nxt; b7_r <= b7_nxt; p_r <= p_nxt; sn_r <= sn_nxt;
    opa_r <= opa_nxt; opb_r <= opb_nxt; op_r <= op_nxt; oi_r <= oi_nxt; oe_r <= oe_nxt;
  end
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  localparam int LIMIT_CYCLES = 2_000_000;

  typedef enum logic [1:0] {
    REG_CALIB_A = 2'd0, REG_CALIB_B = 2'd1, REG_CALIB_C = 2'd2, REG_OSS = 2'd3
  } reg_index_t;

  typedef enum logic {FUNC_TEMP = 1'b0, FUNC_PRESSURE = 1'b1} func_t;

  typedef struct {
    logic signed [31:0] pressure_pa;
    logic               is_pressure;
    logic               divide_error;
  } baro_result_t;

  class baro_scoreboard;
    bit [63:0] calib_a, calib_b;
    bit [31:0] calib_c;
    bit [1:0]  oss;
    bit [15:0] raw_temp;
    baro_result_t pending[$];
    int errors, n_pressure, n_div_err, n_temp;

    function bit [31:0] sext16(bit [15:0] w);
      return {{16{w[15]}}, w};
    endfunction

    function bit [31:0] asr(bit [31:0] v, int s);
      return $unsigned($signed(v) >>> s);
    endfunction

    function bit [31:0] sdiv(bit [31:0] a, bit [31:0] b);
      bit [31:0] ma, mb, q;
      ma = a[31] ? 32'd0 - a : a;
      mb = b[31] ? 32'd0 - b : b;
      q = ma / mb;
      return (a[31] != b[31]) ? 32'd0 - q : q;
    endfunction

    function void write_reg(reg_index_t idx, bit [63:0] data);
      case (idx)
        REG_CALIB_A: calib_a = data;
        REG_CALIB_B: calib_b = data;
        REG_CALIB_C: calib_c = data[31:0];
        REG_OSS:     oss = data[1:0];
      endcase
    endfunction

    function baro_result_t compensate(bit [23:0] raw);
      baro_result_t r;
      bit [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      bit [31:0] up, x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
      ac1 = sext16(calib_a[15:0]);  ac2 = sext16(calib_a[31:16]);
      ac3 = sext16(calib_a[47:32]); ac4 = {16'd0, calib_a[63:48]};
      ac5 = {16'd0, calib_b[15:0]}; ac6 = {16'd0, calib_b[31:16]};
      b1 = sext16(calib_b[47:32]);  b2 = sext16(calib_b[63:48]);
      mc = sext16(calib_c[15:0]);   md = sext16(calib_c[31:16]);
      r.pressure_pa = 0; r.is_pressure = 0; r.divide_error = 0;
      up = {8'd0, raw} >> (8 - oss);
      x1 = asr(({16'd0, raw_temp} - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 0) begin
        r.divide_error = 1;
        return r;
      end
      x2 = sdiv(mc << 11, den);
      b5 = x1 + x2;
      b6 = b5 - 32'd4000;
      sq = asr(b6 * b6, 12);
      x1 = asr(b2 * sq, 11);
      x2 = asr(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = sdiv(((ac1 * 32'd4 + x3) << oss) + 32'd2, 32'd4);
      x1 = asr(ac3 * b6, 13);
      x2 = asr(b1 * sq, 16);
      x3 = asr(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      b7 = (up - b3) * (32'd50000 >> oss);
      if (b4 == 0) begin
        r.divide_error = 1;
        return r;
      end
      if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
      else p = (b7 / b4) * 32'd2;
      x1 = asr(p, 8) * asr(p, 8);
      x1 = asr(x1 * 32'd3038, 16);
      x2 = asr((32'd0 - 32'd7357) * p, 16);
      p = p + asr(x1 + x2 + 32'd3791, 4);
      r.pressure_pa = p;
      r.is_pressure = 1;
      return r;
    endfunction

    function void note_input(func_t f, bit [23:0] raw);
      baro_result_t r;
      if (f == FUNC_TEMP) begin
        raw_temp = raw[15:0];
        r.pressure_pa = 0; r.is_pressure = 0; r.divide_error = 0;
        n_temp++;
      end else begin
        r = compensate(raw);
        if (r.divide_error) n_div_err++;
        else n_pressure++;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] p, logic isp, logic derr);
      baro_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result p=%0d is_pressure=%0b divide_error=%0b",
                 $time, p, isp, derr);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (p !== e.pressure_pa) begin
        $display("%0t: pressure_pa expected %0d actual %0d", $time, e.pressure_pa, p);
        errors++;
      end
      if (isp !== e.is_pressure) begin
        $display("%0t: is_pressure expected %0b actual %0b", $time, e.is_pressure, isp);
        errors++;
      end
      if (derr !== e.divide_error) begin
        $display("%0t: divide_error expected %0b actual %0b", $time, e.divide_error, derr);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0, rst_n = 0;
  logic        in_valid = 0, in_ready;
  logic        in_func = 0;
  logic [23:0] in_raw_sample = 0;
  logic        out_valid, out_ready = 0;
  logic signed [31:0] out_pressure_pa;
  logic        out_is_pressure, out_divide_error;
  logic        cfg_valid = 0, cfg_ready;
  logic [1:0]  cfg_index = 0;
  logic [63:0] cfg_data = 0;

  baro_scoreboard sb;
  int  cycles = 0;
  int  in_gap = 0, out_stall = 0;
  bit  busy_mode = 0;

  barometric_pressure_compensation_core dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_result(out_pressure_pa, out_is_pressure, out_divide_error);
        out_stall = busy_mode ? 0 : $urandom_range(0, 5);
        if (out_stall > 0) out_ready <= 0;
      end else if (out_stall > 0) begin
        out_stall--;
        if (out_stall == 0) out_ready <= 1;
      end else begin
        out_ready <= 1;
      end
    end
  end

  task automatic send_item(func_t f, bit [23:0] raw);
    in_valid <= 1;
    in_func <= f;
    in_raw_sample <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(f, raw);
    in_gap = busy_mode ? 0 : $urandom_range(0, 5);
    if (in_gap > 0) begin
      in_valid <= 0;
      repeat (in_gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (in_gap == 0) begin
      in_valid <= 0;
      @(posedge clk);
    end
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, bit [63:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic load_calib(bit [63:0] a, bit [63:0] b, bit [31:0] c, bit [1:0] o);
    write_reg(REG_CALIB_A, a);
    write_reg(REG_CALIB_B, b);
    write_reg(REG_CALIB_C, c);
    write_reg(REG_OSS, {62'd0, o});
  endtask

  function automatic bit [63:0] typical_a();
    return {16'd32741, 16'(-14383), 16'(-72), 16'd408};
  endfunction

  function automatic bit [63:0] typical_b();
    return {16'd4, 16'd6190, 16'd23153, 16'd32757};
  endfunction

  function automatic bit [31:0] typical_c();
    return {16'd2868, 16'(-8711)};
  endfunction

  task automatic random_phase(int n_items);
    bit [23:0] raw;
    repeat (n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        raw = ($urandom_range(0, 1)) ? 24'(27898 + $urandom_range(0, 4000) - 2000)
                                     : 24'($urandom);
        send_item(FUNC_TEMP, raw);
        raw = ($urandom_range(0, 1)) ? 24'(23843 * 256 + $urandom_range(0, 1 << 20))
                                     : 24'($urandom);
        send_item(FUNC_PRESSURE, raw);
      end else begin
        send_item(func_t'($urandom_range(0, 1)), 24'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset calibration: zero divisor on the temperature path, UT still zero
    send_item(FUNC_PRESSURE, 24'h5D2300);
    send_item(FUNC_TEMP, 24'hFFFFFF);
    send_item(FUNC_PRESSURE, 24'hFFFFFF);
    drain();

    load_calib(typical_a(), typical_b(), typical_c(), 2'd0);
    send_item(FUNC_PRESSURE, 24'h000000);
    send_item(FUNC_TEMP, 24'd27898);
    send_item(FUNC_PRESSURE, 24'd23843 << 8);
    send_item(FUNC_PRESSURE, 24'h000000);
    send_item(FUNC_PRESSURE, 24'hFFFFFF);
    send_item(FUNC_TEMP, 24'h000000);
    send_item(FUNC_PRESSURE, 24'h800000);
    send_item(FUNC_TEMP, 24'h00FFFF);
    send_item(FUNC_PRESSURE, 24'h7FFFFF);
    drain();

    load_calib(typical_a(), typical_b(), typical_c(), 2'd3);
    send_item(FUNC_TEMP, 24'd27898);
    send_item(FUNC_PRESSURE, 24'hFFFFFF);
    send_item(FUNC_PRESSURE, 24'h000001);
    drain();

    // ac4 of zero forces the pressure divisor to zero
    load_calib(typical_a() & 64'h0000_FFFF_FFFF_FFFF, typical_b(), typical_c(), 2'd1);
    send_item(FUNC_TEMP, 24'd27898);
    send_item(FUNC_PRESSURE, 24'h123456);
    drain();

    load_calib('1, '1, '1, 2'd3);
    send_item(FUNC_TEMP, 24'hFFFFFF);
    send_item(FUNC_PRESSURE, 24'hFFFFFF);
    send_item(FUNC_PRESSURE, 24'h000000);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      busy_mode = (ph == 2 || ph == 5);
      case (ph % 4)
        0, 1: load_calib(typical_a(), typical_b(), typical_c(), 2'($urandom_range(0, 3)));
        2: load_calib({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 2'($urandom));
        default: load_calib(typical_a() ^ 64'($urandom_range(0, 255)),
                            typical_b() ^ 64'($urandom_range(0, 255)),
                            typical_c() ^ 32'($urandom_range(0, 255)), 2'd3 - 2'(ph[1:0]));
      endcase
      random_phase(40);
      drain();
    end
    busy_mode = 0;

    $display("tb: %0d temperature beats, %0d compensated pressures, %0d divide errors",
             sb.n_temp, sb.n_pressure, sb.n_div_err);
    $display("tb: %0d cycles, %0d mismatches", cycles, sb.errors);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
